[design/pmgp_pkg.sv]
`timescale 1ns / 1ps

package pmgp_pkg;

    localparam int IDX_W     = 8;
    localparam int QLO_W     = 48;
    localparam int OUT_W     = 48;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 3;
    localparam int GMMAG_W   = 80;
    localparam int R_W       = 32;
    localparam int R2_W      = 64;
    localparam int R3_W      = 96;

    localparam logic [7:0]  BOX_SIDE_RST      = 8'd64;
    localparam logic [7:0]  BORDER_OFFSET_RST = 8'd0;
    localparam logic [31:0] CELL_SIZE_RST     = 32'd67108864;
    localparam logic [47:0] GM_RST            = 48'd4294967296;
    localparam logic [31:0] EPS_DISTANCE_RST  = 32'd16777;

    localparam logic [QLO_W:0] OUT_LIM = 49'h0_8000_0000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOX_SIDE,
        REG_BORDER_OFFSET,
        REG_CELL_SIZE,
        REG_GM,
        REG_EPS_DISTANCE
    } cfg_reg_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx_x;
        logic [IDX_W-1:0] idx_y;
        logic [IDX_W-1:0] idx_z;
    } in_t;

    typedef struct packed {
        logic [23:0]              grid_index;
        logic signed [OUT_W-1:0]  potential;
        logic signed [OUT_W-1:0]  accel_x;
        logic signed [OUT_W-1:0]  accel_y;
        logic signed [OUT_W-1:0]  accel_z;
        logic                     saturated;
    } out_t;

    // sideband carried alongside the root and cube stages
    typedef struct packed {
        logic [23:0]                grid_index;
        logic [2:0]                 neg;
        logic                       sat;
        logic [2:0][GMMAG_W-1:0]    gmmag;
    } side_t;

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic             clip;
    } sat_res_t;

    // magnitude to signed output with clipping
    function automatic sat_res_t sat_out(input logic [QLO_W:0] mag, input logic negative);
        sat_res_t res;
        logic [QLO_W:0] neg_mag;
        neg_mag = '0 - mag;
        res.clip = 1'b0;
        if (negative) begin
            if (mag > OUT_LIM) begin
                res.value = 48'h8000_0000_0000;
                res.clip  = 1'b1;
            end else begin
                res.value = neg_mag[OUT_W-1:0];
            end
        end else begin
            if (mag > OUT_LIM - 49'd1) begin
                res.value = 48'h7FFF_FFFF_FFFF;
                res.clip  = 1'b1;
            end else begin
                res.value = mag[OUT_W-1:0];
            end
        end
        return res;
    endfunction

endpackage

[design/pmgp_offset.sv]
`timescale 1ns / 1ps

module pmgp_offset (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  pmgp_pkg::in_t        in_data,
    input  logic [7:0]           box_side,
    input  logic [7:0]           border_offset,
    input  logic [31:0]          cell_size,
    input  logic [47:0]          gm,
    output logic                 out_valid,
    output logic [pmgp_pkg::R2_W-1:0] r2,
    output pmgp_pkg::side_t      side_out
);

    logic [2:0] v_reg;

    // stage 1: offsets
    logic [2:0][31:0] s1_mag_reg, s1_mag_next;
    logic [2:0]       s1_neg_reg, s1_neg_next;
    logic             s1_sat_reg, s1_sat_next;
    logic [7:0]       s1_x_reg, s1_z_reg;
    logic [16:0]      s1_ys_reg, s1_ys_next;
    logic [17:0]      s1_side2_reg, s1_side2_next;

    // stage 2: products
    logic [2:0][63:0] s2_sq_reg, s2_sq_next;
    logic [2:0][63:0] s2_pl_reg, s2_pl_next;
    logic [2:0][47:0] s2_ph_reg, s2_ph_next;
    logic [2:0]       s2_neg_reg;
    logic             s2_sat_reg;
    logic [7:0]       s2_x_reg;
    logic [16:0]      s2_ys_reg;
    logic [25:0]      s2_zs_reg, s2_zs_next;

    // stage 3: sums
    logic [63:0]      s3_r2_reg, s3_r2_next;
    pmgp_pkg::side_t  s3_side_reg, s3_side_next;

    logic [2:0][7:0]  idx;
    logic [8:0]       side;

    always_comb
    begin
        logic signed [8:0]  delta;
        logic signed [41:0] prod;
        logic signed [42:0] d32;
        logic signed [40:0] d30;
        logic signed [40:0] d30n;
        idx  = {in_data.idx_z, in_data.idx_y, in_data.idx_x};
        side = 9'(box_side) + 9'd1;
        s1_sat_next = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            delta = $signed({1'b0, idx[a]}) - $signed({1'b0, border_offset});
            prod  = 42'(delta) * $signed({10'b0, cell_size});
            d32   = {prod[41], prod} - 43'sh0_8000_0000;
            d30   = d32[42:2];
            d30n  = -d30;
            if (d30 > 41'sh0_7FFF_FFFF)
            begin
                s1_mag_next[a] = 32'h7FFF_FFFF;
                s1_neg_next[a] = 1'b0;
                s1_sat_next    = 1'b1;
            end
            else if (d30 < -41'sh0_8000_0000)
            begin
                s1_mag_next[a] = 32'h8000_0000;
                s1_neg_next[a] = 1'b1;
                s1_sat_next    = 1'b1;
            end
            else
            begin
                s1_neg_next[a] = d30[40];
                s1_mag_next[a] = d30[40] ? d30n[31:0] : d30[31:0];
            end
        end
        s1_ys_next    = 17'(in_data.idx_y) * 17'(side);
        s1_side2_next = 18'(side) * 18'(side);
    end

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            s2_sq_next[a] = 64'(s1_mag_reg[a]) * 64'(s1_mag_reg[a]);
            s2_pl_next[a] = 64'(gm[31:0]) * 64'(s1_mag_reg[a]);
            s2_ph_next[a] = 48'(gm[47:32]) * 48'(s1_mag_reg[a]);
        end
        s2_zs_next = 26'(s1_z_reg) * 26'(s1_side2_reg);
    end

    always_comb
    begin
        logic [26:0] gsum;
        s3_r2_next = s2_sq_reg[0] + s2_sq_reg[1] + s2_sq_reg[2];
        gsum = 27'(s2_x_reg) + 27'(s2_ys_reg) + 27'(s2_zs_reg);
        s3_side_next.grid_index = gsum[23:0];
        s3_side_next.neg = s2_neg_reg;
        s3_side_next.sat = s2_sat_reg;
        for (int a = 0; a < 3; a++)
        begin
            s3_side_next.gmmag[a] = {s2_ph_reg[a], 32'b0} + 80'(s2_pl_reg[a]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_mag_reg   <= s1_mag_next;
            s1_neg_reg   <= s1_neg_next;
            s1_sat_reg   <= s1_sat_next;
            s1_x_reg     <= in_data.idx_x;
            s1_z_reg     <= in_data.idx_z;
            s1_ys_reg    <= s1_ys_next;
            s1_side2_reg <= s1_side2_next;
            s2_sq_reg    <= s2_sq_next;
            s2_pl_reg    <= s2_pl_next;
            s2_ph_reg    <= s2_ph_next;
            s2_neg_reg   <= s1_neg_reg;
            s2_sat_reg   <= s1_sat_reg;
            s2_x_reg     <= s1_x_reg;
            s2_ys_reg    <= s1_ys_reg;
            s2_zs_reg    <= s2_zs_next;
            s3_r2_reg    <= s3_r2_next;
            s3_side_reg  <= s3_side_next;
        end
    end

    assign out_valid = v_reg[2];
    assign r2        = s3_r2_reg;
    assign side_out  = s3_side_reg;

endmodule

[design/pmgp_sqrt.sv]
`timescale 1ns / 1ps

module pmgp_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [pmgp_pkg::R2_W-1:0]     radicand,
    input  logic [SIDE_W-1:0]             side_in,
    output logic                          out_valid,
    output logic [pmgp_pkg::R_W-1:0]      root,
    output logic [SIDE_W-1:0]             side_out
);

    localparam int STAGES = pmgp_pkg::R_W;
    localparam int REM_W  = pmgp_pkg::R_W + 2;

    logic                          v_reg    [0:STAGES];
    logic [SIDE_W-1:0]             side_reg [0:STAGES];
    logic [pmgp_pkg::R_W-1:0]      root_reg [0:STAGES];
    logic [pmgp_pkg::R2_W-1:0]     x_reg    [0:STAGES-1];
    logic [REM_W-1:0]              rem_reg  [0:STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            side_reg[0] <= side_in;
            root_reg[0] <= '0;
            x_reg[0]    <= radicand;
            rem_reg[0]  <= '0;
        end
    end

    // one root bit per stage
    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [REM_W+1:0] t;
        logic [REM_W+1:0] trial;
        logic [REM_W+1:0] diff;
        logic             take;

        always_comb
        begin
            t     = {rem_reg[s], x_reg[s][pmgp_pkg::R2_W-1 -: 2]};
            trial = {2'b0, root_reg[s], 2'b01};
            diff  = t - trial;
            take  = (t >= trial);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s+1] <= v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                side_reg[s+1] <= side_reg[s];
                root_reg[s+1] <= {root_reg[s][pmgp_pkg::R_W-2:0], take};
            end
        end

        if (s < STAGES - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    x_reg[s+1]   <= {x_reg[s][pmgp_pkg::R2_W-3:0], 2'b00};
                    rem_reg[s+1] <= take ? diff[REM_W-1:0] : t[REM_W-1:0];
                end
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign root      = root_reg[STAGES];
    assign side_out  = side_reg[STAGES];

endmodule

[design/pmgp_cube.sv]
`timescale 1ns / 1ps

module pmgp_cube #(
    parameter int SIDE_W = 1
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [pmgp_pkg::R_W-1:0]  root,
    input  logic [31:0]               eps_distance,
    input  logic [SIDE_W-1:0]         side_in,
    output logic                      out_valid,
    output logic [pmgp_pkg::R_W-1:0]  r,
    output logic [pmgp_pkg::R3_W-1:0] r3,
    output logic [SIDE_W-1:0]         side_out
);

    logic [3:0]        v_reg;
    logic [SIDE_W-1:0] side_reg [0:3];
    logic [31:0]       r_reg    [0:3];
    logic [31:0]       r_next;
    logic [63:0]       rr_reg, rr_next;
    logic [63:0]       plo_reg, plo_next, phi_reg, phi_next;
    logic [95:0]       r3_reg, r3_next;

    always_comb
    begin
        // centre point falls back to the epsilon distance, never zero
        if (root == '0)
        begin
            r_next = (eps_distance == '0) ? 32'd1 : eps_distance;
        end
        else
        begin
            r_next = root;
        end
        rr_next  = 64'(r_reg[0]) * 64'(r_reg[0]);
        plo_next = 64'(rr_reg[31:0]) * 64'(r_reg[1]);
        phi_next = 64'(rr_reg[63:32]) * 64'(r_reg[1]);
        r3_next  = {phi_reg, 32'b0} + 96'(plo_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg[0]    <= r_next;
            r_reg[1]    <= r_reg[0];
            r_reg[2]    <= r_reg[1];
            r_reg[3]    <= r_reg[2];
            side_reg[0] <= side_in;
            side_reg[1] <= side_reg[0];
            side_reg[2] <= side_reg[1];
            side_reg[3] <= side_reg[2];
            rr_reg      <= rr_next;
            plo_reg     <= plo_next;
            phi_reg     <= phi_next;
            r3_reg      <= r3_next;
        end
    end

    assign out_valid = v_reg[3];
    assign r         = r_reg[3];
    assign r3        = r3_reg;
    assign side_out  = side_reg[3];

endmodule

[design/pmgp_div.sv]
`timescale 1ns / 1ps

module pmgp_div #(
    parameter int HI_W   = 32,
    parameter int SIDE_W = 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  logic                         in_valid,
    input  logic [HI_W-1:0]              hi,
    input  logic [pmgp_pkg::QLO_W-1:0]   lo,
    input  logic [HI_W-1:0]              den,
    input  logic [SIDE_W-1:0]            side_in,
    output logic                         out_valid,
    output logic [pmgp_pkg::QLO_W:0]     quot,
    output logic [SIDE_W-1:0]            side_out
);

    localparam int STAGES = pmgp_pkg::QLO_W;

    logic                          v_reg    [0:STAGES];
    logic                          cap_reg  [0:STAGES];
    logic [SIDE_W-1:0]             side_reg [0:STAGES];
    logic [pmgp_pkg::QLO_W-1:0]    q_reg    [0:STAGES];
    logic [HI_W-1:0]               rem_reg  [0:STAGES-1];
    logic [HI_W-1:0]               den_reg  [0:STAGES-1];
    logic [pmgp_pkg::QLO_W-1:0]    lo_reg   [0:STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
        end
    end

    // quotient at or above the cap is decided up front from the high part
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cap_reg[0]  <= (hi >= den);
            side_reg[0] <= side_in;
            q_reg[0]    <= '0;
            rem_reg[0]  <= hi;
            den_reg[0]  <= den;
            lo_reg[0]   <= lo;
        end
    end

    for (genvar s = 0; s < STAGES; s++)
    begin : g_stage
        logic [HI_W:0] t;
        logic [HI_W:0] diff;
        logic          take;

        always_comb
        begin
            t    = {rem_reg[s], lo_reg[s][pmgp_pkg::QLO_W-1]};
            diff = t - {1'b0, den_reg[s]};
            take = (t >= {1'b0, den_reg[s]});
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[s+1] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[s+1] <= v_reg[s];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cap_reg[s+1]  <= cap_reg[s];
                side_reg[s+1] <= side_reg[s];
                q_reg[s+1]    <= {q_reg[s][pmgp_pkg::QLO_W-2:0], take};
            end
        end

        if (s < STAGES - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s+1] <= take ? diff[HI_W-1:0] : t[HI_W-1:0];
                    den_reg[s+1] <= den_reg[s];
                    lo_reg[s+1]  <= {lo_reg[s][pmgp_pkg::QLO_W-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = v_reg[STAGES];
    assign quot      = cap_reg[STAGES] ? {1'b1, {pmgp_pkg::QLO_W{1'b0}}}
                                       : {1'b0, q_reg[STAGES]};
    assign side_out  = side_reg[STAGES];

endmodule

[design/point_mass_grid_potential_unit.sv]
`timescale 1ns / 1ps

// point mass potential and acceleration over a cubic grid. each input transaction names one
// grid point; the unit returns its linear index, the potential -gm/r and the acceleration
// -gm*d/r^3 per axis, saturated to signed Q16.32 with a saturation flag per result. the
// pipeline takes one point every cycle and is built from 3 stages of offset, square and
// product arithmetic, 33 stages of the bit-per-stage square root, 4 stages forming r and r
// cubed, 49 stages of the bit-per-stage dividers (one for the potential, one per axis) and
// the output register. the whole pipe holds while a finished result waits and out_ready is
// low. the user must see that registers are written through the cfg port only while the
// unit is idle; the block itself does not enforce this.
module point_mass_grid_potential_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  pmgp_pkg::in_t                     in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output pmgp_pkg::out_t                    out_data,
    input  logic                              cfg_we,
    input  logic [pmgp_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [pmgp_pkg::CFG_W-1:0]        cfg_data
);

    localparam int SIDE_W = $bits(pmgp_pkg::side_t);

    // configuration registers
    logic [7:0]  box_side_reg;
    logic [7:0]  border_offset_reg;
    logic [31:0] cell_size_reg;
    logic [47:0] gm_reg;
    logic [31:0] eps_distance_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_side_reg      <= pmgp_pkg::BOX_SIDE_RST;
            border_offset_reg <= pmgp_pkg::BORDER_OFFSET_RST;
            cell_size_reg     <= pmgp_pkg::CELL_SIZE_RST;
            gm_reg            <= pmgp_pkg::GM_RST;
            eps_distance_reg  <= pmgp_pkg::EPS_DISTANCE_RST;
        end
        else if (cfg_we)
        begin
            unique case (pmgp_pkg::cfg_reg_t'(cfg_index))
                pmgp_pkg::REG_BOX_SIDE:      box_side_reg      <= cfg_data[7:0];
                pmgp_pkg::REG_BORDER_OFFSET: border_offset_reg <= cfg_data[7:0];
                pmgp_pkg::REG_CELL_SIZE:     cell_size_reg     <= cfg_data[31:0];
                pmgp_pkg::REG_GM:            gm_reg            <= cfg_data;
                pmgp_pkg::REG_EPS_DISTANCE:  eps_distance_reg  <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    // global advance: the pipe moves unless the output holds an untaken result
    logic en;
    logic out_valid_reg;
    pmgp_pkg::out_t out_reg, out_next;

    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // offsets, squares and gm products
    logic                         off_valid;
    logic [pmgp_pkg::R2_W-1:0]    off_r2;
    pmgp_pkg::side_t              off_side;

    pmgp_offset u_offset (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .in_valid      (in_valid),
        .in_data       (in_data),
        .box_side      (box_side_reg),
        .border_offset (border_offset_reg),
        .cell_size     (cell_size_reg),
        .gm            (gm_reg),
        .out_valid     (off_valid),
        .r2            (off_r2),
        .side_out      (off_side)
    );

    // distance
    logic                         sq_valid;
    logic [pmgp_pkg::R_W-1:0]     sq_root;
    logic [SIDE_W-1:0]            sq_side;

    pmgp_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (off_valid),
        .radicand  (off_r2),
        .side_in   (off_side),
        .out_valid (sq_valid),
        .root      (sq_root),
        .side_out  (sq_side)
    );

    // r with the centre fallback, and r cubed
    logic                         cb_valid;
    logic [pmgp_pkg::R_W-1:0]     cb_r;
    logic [pmgp_pkg::R3_W-1:0]    cb_r3;
    logic [SIDE_W-1:0]            cb_side_bits;
    pmgp_pkg::side_t              cb_side;

    pmgp_cube #(.SIDE_W(SIDE_W)) u_cube (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (sq_valid),
        .root         (sq_root),
        .eps_distance (eps_distance_reg),
        .side_in      (sq_side),
        .out_valid    (cb_valid),
        .r            (cb_r),
        .r3           (cb_r3),
        .side_out     (cb_side_bits)
    );

    assign cb_side = pmgp_pkg::side_t'(cb_side_bits);

    // potential divider: gm * 2^30 / r, split into the part above and below the cap
    logic                         pot_valid;
    logic [pmgp_pkg::QLO_W:0]     pot_q;
    logic [24:0]                  pot_side;

    pmgp_div #(.HI_W(pmgp_pkg::R_W), .SIDE_W(25)) u_div_pot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (cb_valid),
        .hi        (32'(gm_reg[47:18])),
        .lo        ({gm_reg[17:0], 30'b0}),
        .den       (cb_r),
        .side_in   ({cb_side.grid_index, cb_side.sat}),
        .out_valid (pot_valid),
        .quot      (pot_q),
        .side_out  (pot_side)
    );

    // acceleration dividers: gm * |d| * 2^60 / r^3 per axis
    logic [2:0]                   acc_valid;
    logic [pmgp_pkg::QLO_W:0]     acc_q   [0:2];
    logic [2:0]                   acc_neg;

    for (genvar a = 0; a < 3; a++)
    begin : g_acc
        pmgp_div #(.HI_W(pmgp_pkg::R3_W), .SIDE_W(1)) u_div_acc (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (cb_valid),
            .hi        ({4'b0, cb_side.gmmag[a], 12'b0}),
            .lo        ('0),
            .den       (cb_r3),
            .side_in   (cb_side.neg[a]),
            .out_valid (acc_valid[a]),
            .quot      (acc_q[a]),
            .side_out  (acc_neg[a])
        );
    end

    // sign and clip
    always_comb
    begin
        pmgp_pkg::sat_res_t pr;
        pmgp_pkg::sat_res_t ax;
        pmgp_pkg::sat_res_t ay;
        pmgp_pkg::sat_res_t az;
        pr = pmgp_pkg::sat_out(pot_q, 1'b1);
        // acceleration points against the offset
        ax = pmgp_pkg::sat_out(acc_q[0], !acc_neg[0]);
        ay = pmgp_pkg::sat_out(acc_q[1], !acc_neg[1]);
        az = pmgp_pkg::sat_out(acc_q[2], !acc_neg[2]);
        out_next.grid_index = pot_side[24:1];
        out_next.potential  = pr.value;
        out_next.accel_x    = ax.value;
        out_next.accel_y    = ay.value;
        out_next.accel_z    = az.value;
        out_next.saturated  = pot_side[0] | pr.clip | ax.clip | ay.clip | az.clip;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= pot_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // the four dividers run in lock step
    a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (pot_valid == acc_valid[0]) && (pot_valid == acc_valid[1])
            && (pot_valid == acc_valid[2]))
        else $error("divider valid bits diverged");

    // a capped potential quotient must raise the flag
    a_cap_flag: assert property (@(posedge clk) disable iff (!rst_n)
        (en && pot_valid && pot_q[pmgp_pkg::QLO_W]) |=> out_data.saturated)
        else $error("capped potential without saturated flag");

    // the potential is never positive
    a_pot_sign: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ($signed(out_data.potential) <= 48'sd0))
        else $error("positive potential");

endmodule
